@@ rtl/pwk_pkg.sv @@
// Shared types, codes and the entry address helper of the page table walker.
package pwk_pkg;

    localparam int unsigned ADDR_W         = 64;
    localparam int unsigned OFFSET_W       = 12;
    localparam int unsigned INDEX_W        = 9;
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam logic ACTION_TRANSLATE = 1'b0;
    localparam logic ACTION_RESPONSE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } result_kind_t;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        LEVEL_1 = 2'd0,
        LEVEL_2 = 2'd1,
        LEVEL_3 = 2'd2,
        LEVEL_4 = 2'd3
    } level_t;

    // One classified item on its way from the front part to the back part.
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] data;
    } queue_entry_t;

    // Address of the entry for the given level inside the table at base.
    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [ADDR_W-1:0] base,
        input level_t            lvl,
        input logic [ADDR_W-1:0] vaddr
    );
        logic [INDEX_W-1:0] idx;
        unique case (lvl)
            LEVEL_4: idx = vaddr[47:39];
            LEVEL_3: idx = vaddr[38:30];
            LEVEL_2: idx = vaddr[29:21];
            LEVEL_1: idx = vaddr[20:12];
            default: idx = '0;
        endcase
        return {base[ADDR_W-1:OFFSET_W], idx, 3'b000};
    endfunction

endpackage

@@ rtl/pwk_front.sv @@
// Front stage of the walker: accepts input items and classifies them for the queue.
module pwk_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [pwk_pkg::ADDR_W-1:0]       req_vaddr,
    input  logic [pwk_pkg::ADDR_W-1:0]       read_data,
    output logic                             push_valid,
    input  logic                             push_ready,
    output pwk_pkg::queue_entry_t            push_entry
);
    import pwk_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    queue_entry_t entry_reg;
    queue_entry_t entry_next;
    logic         take;

    assign in_ready   = !valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    // The item carries only the field that its action uses.
    always_comb
    begin
        valid_next = valid_reg && !push_ready;
        entry_next = entry_reg;
        if (take)
        begin
            valid_next = 1'b1;
            if (action == ACTION_RESPONSE)
            begin
                entry_next.op   = OP_RESPONSE;
                entry_next.data = read_data;
            end
            else
            begin
                entry_next.op   = OP_TRANSLATE;
                entry_next.data = req_vaddr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/pwk_queue.sv @@
// Short first-in first-out queue between the front and back parts of the walker.
module pwk_queue #(
    parameter int unsigned DEPTH = pwk_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  pwk_pkg::queue_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output pwk_pkg::queue_entry_t pop_entry
);
    import pwk_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    queue_entry_t     slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/pwk_back.sv @@
// Back part of the walker: walk state, root register and the result register.
module pwk_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [pwk_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  pwk_pkg::queue_entry_t            pop_entry,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       result_kind,
    output logic [pwk_pkg::ADDR_W-1:0]       out_addr
);
    import pwk_pkg::*;

    logic [ADDR_W-1:0] root_table_base_reg;
    logic              busy_reg;
    logic              busy_next;
    level_t            level_reg;
    level_t            level_next;
    logic [ADDR_W-1:0] saved_vaddr_reg;
    logic [ADDR_W-1:0] saved_vaddr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_kind_t      kind_reg;
    result_kind_t      kind_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] base;
    logic              pop;

    // An item leaves the queue whenever the result register is free or being emptied.
    assign pop_ready   = !out_valid_reg || out_ready;
    assign pop         = pop_valid && pop_ready;
    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_addr    = addr_reg;
    assign base        = {pop_entry.data[ADDR_W-1:OFFSET_W], {OFFSET_W{1'b0}}};

    always_comb
    begin
        busy_next        = busy_reg;
        level_next       = level_reg;
        saved_vaddr_next = saved_vaddr_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        addr_next        = addr_reg;
        if (pop)
        begin
            unique case (pop_entry.op)
                OP_TRANSLATE:
                begin
                    // A request during a walk is dropped without a result.
                    if (!busy_reg)
                    begin
                        saved_vaddr_next = pop_entry.data;
                        busy_next        = 1'b1;
                        level_next       = LEVEL_4;
                        out_valid_next   = 1'b1;
                        kind_next        = KIND_READ;
                        addr_next        = entry_addr(root_table_base_reg, LEVEL_4,
                                                      pop_entry.data);
                    end
                end
                OP_RESPONSE:
                begin
                    // A response with no walk in progress is dropped.
                    if (busy_reg)
                    begin
                        out_valid_next = 1'b1;
                        if (!pop_entry.data[0])
                        begin
                            busy_next  = 1'b0;
                            level_next = LEVEL_1;
                            kind_next  = KIND_FAULT;
                            addr_next  = '0;
                        end
                        else if (level_reg == LEVEL_1)
                        begin
                            busy_next = 1'b0;
                            kind_next = KIND_DONE;
                            addr_next = {base[ADDR_W-1:OFFSET_W],
                                         saved_vaddr_reg[OFFSET_W-1:0]};
                        end
                        else
                        begin
                            level_next = level_t'(level_reg - 2'd1);
                            kind_next  = KIND_READ;
                            addr_next  = entry_addr(base, level_t'(level_reg - 2'd1),
                                                    saved_vaddr_reg);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_table_base_reg <= '0;
            busy_reg            <= 1'b0;
            level_reg           <= LEVEL_1;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                root_table_base_reg <= cfg_data;
            end
            busy_reg      <= busy_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        saved_vaddr_reg <= saved_vaddr_next;
        kind_reg        <= kind_next;
        addr_reg        <= addr_next;
    end

endmodule

@@ rtl/four_level_page_table_walker_core.sv @@
// Top level of the four-level page table walker.
//
// This walker translates a 64-bit virtual address through four levels of
// 4 KiB page tables. A translate item starts a walk and yields a read request
// for the level-4 entry; each memory response item is checked for its present
// bit and yields either the next read request, the final physical address
// (frame base ORed with the page offset), or a not-mapped fault with a zero
// address. A translate item that arrives during a walk, and a response that
// arrives with no walk in progress, are dropped and yield no result. The
// block takes one input transfer per cycle and delivers at most one result
// transfer per cycle, sustained as long as the result side keeps up. An item
// passes through the front register, the classification queue and the back
// result register. The queue of QUEUE_DEPTH entries absorbs stalls on the
// result side before the input side sees ready fall. The root table base is
// written through the configuration channel, which is always ready; write it only
// while no walk is pending and no item is in flight.
module four_level_page_table_walker_core #(
    parameter int unsigned QUEUE_DEPTH = pwk_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pwk_pkg::ADDR_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [pwk_pkg::ADDR_W-1:0] req_vaddr,
    input  logic [pwk_pkg::ADDR_W-1:0] read_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 result_kind,
    output logic [pwk_pkg::ADDR_W-1:0] out_addr
);
    import pwk_pkg::*;

    logic         push_valid;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         pop_valid;
    logic         pop_ready;
    queue_entry_t pop_entry;

    // The root register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // The front stage registers each accepted item with its classification.
    pwk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .req_vaddr  (req_vaddr),
        .read_data  (read_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // The queue lets the front keep accepting while the result side stalls.
    pwk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // The back part owns the walk state and drives the result channel.
    pwk_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .out_addr    (out_addr)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the four-level page table walker core.
module tb_top;
    import pwk_pkg::*;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 9;
    // The drain wait covers any dropped item still inside the front register,
    // the queue or the back result register.
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_PHASES = 5;
    localparam int unsigned PHASE_RESULTS = 286;
    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    // Stall patterns of the result side.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_LONG     = 3;

    typedef struct {
        result_kind_t      kind;
        logic [ADDR_W-1:0] addr;
    } walk_result_t;

    // Every input of the block starts at a known value.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              action    = OP_TRANSLATE;
    logic [ADDR_W-1:0] req_vaddr = '0;
    logic [ADDR_W-1:0] read_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        result_kind;
    logic [ADDR_W-1:0] out_addr;

    // Shadow copy of the walker state and of the root table base.
    logic              walk_busy  = 1'b0;
    level_t            walk_lvl   = LEVEL_1;
    logic [ADDR_W-1:0] walk_vaddr = '0;
    logic [ADDR_W-1:0] root_base  = '0;

    // Results that the walker still owes, oldest first.
    walk_result_t walk_results_due[$];

    int unsigned burst_left   = 0;
    int unsigned cycle_count  = 0;
    int unsigned n_transfers  = 0;
    int unsigned n_predicted  = 0;
    int unsigned n_reads      = 0;
    int unsigned n_done       = 0;
    int unsigned n_faults     = 0;
    int unsigned n_dropped    = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_checked    = 0;
    int unsigned n_errors     = 0;

    int rx_mode = RX_ALWAYS;
    int rx_run  = 0;
    int rx_tick = 0;

    four_level_page_table_walker_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .req_vaddr  (req_vaddr),
        .read_data  (read_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_kind(result_kind),
        .out_addr   (out_addr)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Address of the table entry for one level: the nine index bits of that
    // level sit above a three-bit entry offset inside the 4 KiB aligned table.
    function automatic logic [ADDR_W-1:0] table_entry_addr(
        input logic [ADDR_W-1:0] base,
        input level_t            lvl,
        input logic [ADDR_W-1:0] vaddr
    );
        int unsigned        shift;
        logic [INDEX_W-1:0] idx;
        shift = OFFSET_W + INDEX_W * int'(lvl);
        idx   = vaddr[shift +: INDEX_W];
        return {base[ADDR_W-1:OFFSET_W], idx, 3'b000};
    endfunction

    function automatic void push_result(input result_kind_t kind,
                                        input logic [ADDR_W-1:0] addr);
        walk_result_t r;
        r.kind = kind;
        r.addr = addr;
        walk_results_due.push_back(r);
        n_predicted++;
        case (kind)
            KIND_READ: n_reads++;
            KIND_DONE: n_done++;
            default:   n_faults++;
        endcase
    endfunction

    // Advances the shadow walker by one accepted input transfer and queues
    // the result that it owes, if any.
    function automatic void walk_step(
        input op_t               op,
        input logic [ADDR_W-1:0] va,
        input logic [ADDR_W-1:0] entry
    );
        if (op == OP_TRANSLATE)
        begin
            // A new request during a walk is dropped.
            if (walk_busy)
            begin
                n_dropped++;
                return;
            end
            walk_vaddr = va;
            walk_busy  = 1'b1;
            walk_lvl   = LEVEL_4;
            push_result(KIND_READ, table_entry_addr(root_base, LEVEL_4, va));
        end
        else if (!walk_busy)
        begin
            // A memory response with no walk in progress is dropped.
            n_dropped++;
        end
        else if (!entry[0])
        begin
            // Entry not present: the walk ends with a fault and a zero address.
            walk_busy = 1'b0;
            walk_lvl  = LEVEL_1;
            push_result(KIND_FAULT, '0);
        end
        else if (walk_lvl == LEVEL_1)
        begin
            // Frame address keeps every entry bit above the page offset.
            walk_busy = 1'b0;
            push_result(KIND_DONE, {entry[ADDR_W-1:OFFSET_W], walk_vaddr[OFFSET_W-1:0]});
        end
        else
        begin
            walk_lvl = level_t'(walk_lvl - 2'd1);
            push_result(KIND_READ, table_entry_addr(entry, walk_lvl, walk_vaddr));
        end
    endfunction

    // Sends one input item. The sender works in bursts; between bursts it
    // may drop valid for a random gap. Valid is never lowered here after a
    // transfer, so a following item in the same burst keeps it high.
    task automatic send_item(
        input op_t               op,
        input logic [ADDR_W-1:0] va,
        input logic [ADDR_W-1:0] entry
    );
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        action    <= op;
        req_vaddr <= va;
        read_data <= entry;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_transfers++;
        walk_step(op, va, entry);
    endtask

    // Lowers valid and waits until every owed result has arrived and any
    // dropped item has left the pipeline.
    task automatic settle_walker();
        in_valid <= 1'b0;
        while (walk_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Feeds random responses until the open walk, if any, has ended.
    task automatic close_walk();
        logic [ADDR_W-1:0] entry;
        while (walk_busy)
        begin
            entry = {$urandom, $urandom};
            send_item(OP_RESPONSE, '0, entry);
        end
    endtask

    task automatic write_root(input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        root_base = value;
        n_cfg_writes++;
    endtask

    // The root base comes out of reset as zero. A stray response comes first
    // and must be dropped; then a full walk over all-ones entries shows that
    // the top address bits survive into the frame address.
    task automatic test_reset_root();
        send_item(OP_RESPONSE, '0, ALL_ONES);
        send_item(OP_TRANSLATE, ALL_ONES, '0);
        repeat (4) send_item(OP_RESPONSE, '0, ALL_ONES);
        settle_walker();
    endtask

    // With an all-ones root, a walk of virtual address zero over entries that
    // hold only the present bit. A second request during the walk is dropped.
    task automatic test_walk_and_drops();
        write_root(ALL_ONES);
        send_item(OP_TRANSLATE, '0, '0);
        send_item(OP_TRANSLATE, ALL_ONES, ALL_ONES);
        repeat (4) send_item(OP_RESPONSE, ALL_ONES, 64'h1);
        settle_walker();
    endtask

    // A fault on the very first entry, with many other entry bits set, and a
    // fault on the last one, with an all-zero entry.
    task automatic test_fault_levels();
        send_item(OP_TRANSLATE, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_item(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(OP_TRANSLATE, 64'h5555_5555_5555_5555, '0);
        repeat (3) send_item(OP_RESPONSE, '0, 64'h8000_0000_0000_0001);
        send_item(OP_RESPONSE, '0, 64'h0);
        settle_walker();
    endtask

    // Mostly well-formed walks with random addresses and entries, about one
    // response in ten faulting, mixed with stray requests and responses.
    task automatic run_random_phase(input int unsigned target);
        int unsigned       first;
        int unsigned       pick;
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] entry;
        first = n_predicted;
        while (n_predicted - first < target)
        begin
            pick  = $urandom_range(0, 19);
            va    = {$urandom, $urandom};
            entry = {$urandom, $urandom};
            if (pick == 0)
                send_item(OP_TRANSLATE, va, entry);
            else if (pick == 1)
                send_item(OP_RESPONSE, va, entry);
            else if (!walk_busy)
                send_item(OP_TRANSLATE, va, entry);
            else
            begin
                if (pick == 2)
                    entry = ALL_ONES;
                else if (pick == 3)
                    entry = '0;
                entry[0] = ($urandom_range(0, 9) != 0);
                send_item(OP_RESPONSE, va, entry);
            end
        end
        close_walk();
        settle_walker();
    endtask

    // Each phase runs under its own root base, the extremes among them; a
    // root with only its low bits set must act as zero.
    task automatic test_random_walks();
        logic [ADDR_W-1:0] roots [RANDOM_PHASES];
        roots[0] = '0;
        roots[1] = ALL_ONES;
        roots[2] = {$urandom, $urandom};
        roots[3] = 64'h0000_0000_0000_0FFF;
        roots[4] = {$urandom, $urandom};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_root(roots[p]);
            run_random_phase(PHASE_RESULTS);
        end
    endtask

    // Result side: ready follows one of several patterns, each for a random
    // stretch, from always ready to random and periodic stalls.
    always @(posedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_mode = $urandom_range(RX_ALWAYS, RX_LONG);
            rx_run  = $urandom_range(16, 160);
            rx_tick = 0;
        end
        rx_run--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS:   out_ready <= 1'b1;
            RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: out_ready <= ((rx_tick % 5) < 3);
            default:     out_ready <= ((rx_tick % 16) >= 12);
        endcase
    end

    // Each result transfer is checked field by field against the oldest
    // owed result.
    always @(posedge clk)
    begin
        walk_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (walk_results_due.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d addr %h",
                         $time, result_kind, out_addr);
            end
            else
            begin
                want = walk_results_due.pop_front();
                n_checked++;
                if (result_kind !== want.kind)
                begin
                    n_errors++;
                    $display("%0t: result_kind mismatch, expected %0d actual %0d",
                             $time, want.kind, result_kind);
                end
                if (out_addr !== want.addr)
                begin
                    n_errors++;
                    $display("%0t: out_addr mismatch, expected %h actual %h",
                             $time, want.addr, out_addr);
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, walk_results_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_root();
        test_walk_and_drops();
        test_fault_levels();
        test_random_walks();

        settle_walker();
        $display("%0d input transfers, %0d dropped; %0d results checked:",
                 n_transfers, n_dropped, n_checked);
        $display("%0d reads, %0d done, %0d faults, %0d root base writes, %0d mismatches",
                 n_reads, n_done, n_faults, n_cfg_writes, n_errors);
        if (n_errors == 0 && walk_results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
